>>> hw/rtl/tcgw_pkg.sv
// ----------------------------------------------------------------------------
// tcgw_pkg
// Types, constants and the 5x7 glyph ROM shared by the text cell glyph writer.
// ----------------------------------------------------------------------------
package tcgw_pkg;

  typedef enum logic [1:0] {
    KIND_PUT   = 2'd0,
    KIND_CLEAR = 2'd1,
    KIND_EMPTY = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  localparam int          CELL_LINES   = 16;
  localparam logic [3:0]  LAST_LINE    = 4'(CELL_LINES - 1);
  localparam logic [3:0]  GLYPH_FIRST  = 4'd4;
  localparam logic [3:0]  GLYPH_LAST   = 4'd10;
  localparam logic [7:0]  GLYPH_LOW    = 8'h20;  // first code with a glyph
  localparam logic [7:0]  GLYPH_HIGH   = 8'h5F;  // last code with a glyph

  typedef struct packed {
    kind_t       kind;
    logic [6:0]  column;
    logic [5:0]  row;
    logic [7:0]  char_code;
  } in_item_t;

  typedef struct packed {
    logic        write_valid;
    logic [16:0] byte_offset;
    logic [7:0]  pixel_bits;
    logic        last;
    logic        box_empty;
    logic [7:0]  box_left;
    logic [10:0] box_top;
    logic [7:0]  box_right;
    logic [10:0] box_bottom;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  left;
    logic [10:0] top;
    logic [7:0]  right;
    logic [10:0] bottom;
  } box_t;

  typedef struct packed {
    logic        single;   // one result, no write
    logic [6:0]  column;
    logic [5:0]  row;
    logic [5:0]  glyph;
    box_t        box;
  } job_t;

  typedef struct packed {
    logic        clear;
    logic        wr_en;
    logic [6:0]  wr_col;
    logic [6:0]  wr_val;
  } cache_cmd_t;

  // glyph rows packed top row first, 5 bits each
  localparam logic [34:0] GLYPH_ROM [64] = '{
    {5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0},
    {5'd4, 5'd4, 5'd4, 5'd4, 5'd4, 5'd0, 5'd4},
    {5'd10, 5'd10, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0},
    {5'd10, 5'd31, 5'd10, 5'd10, 5'd31, 5'd10, 5'd0},
    {5'd4, 5'd15, 5'd20, 5'd14, 5'd5, 5'd30, 5'd4},
    {5'd25, 5'd26, 5'd2, 5'd4, 5'd8, 5'd11, 5'd19},
    {5'd12, 5'd18, 5'd20, 5'd8, 5'd21, 5'd18, 5'd13},
    {5'd4, 5'd4, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0},
    {5'd2, 5'd4, 5'd8, 5'd8, 5'd8, 5'd4, 5'd2},
    {5'd8, 5'd4, 5'd2, 5'd2, 5'd2, 5'd4, 5'd8},
    {5'd0, 5'd10, 5'd4, 5'd31, 5'd4, 5'd10, 5'd0},
    {5'd0, 5'd4, 5'd4, 5'd31, 5'd4, 5'd4, 5'd0},
    {5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd4, 5'd8},
    {5'd0, 5'd0, 5'd0, 5'd31, 5'd0, 5'd0, 5'd0},
    {5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd12, 5'd12},
    {5'd1, 5'd2, 5'd2, 5'd4, 5'd8, 5'd8, 5'd16},
    {5'd14, 5'd17, 5'd19, 5'd21, 5'd25, 5'd17, 5'd14},
    {5'd4, 5'd12, 5'd4, 5'd4, 5'd4, 5'd4, 5'd14},
    {5'd14, 5'd17, 5'd1, 5'd2, 5'd4, 5'd8, 5'd31},
    {5'd31, 5'd2, 5'd4, 5'd2, 5'd1, 5'd17, 5'd14},
    {5'd2, 5'd6, 5'd10, 5'd18, 5'd31, 5'd2, 5'd2},
    {5'd31, 5'd16, 5'd30, 5'd1, 5'd1, 5'd17, 5'd14},
    {5'd6, 5'd8, 5'd16, 5'd30, 5'd17, 5'd17, 5'd14},
    {5'd31, 5'd1, 5'd2, 5'd4, 5'd8, 5'd8, 5'd8},
    {5'd14, 5'd17, 5'd17, 5'd14, 5'd17, 5'd17, 5'd14},
    {5'd14, 5'd17, 5'd17, 5'd15, 5'd1, 5'd2, 5'd12},
    {5'd0, 5'd12, 5'd12, 5'd0, 5'd12, 5'd12, 5'd0},
    {5'd0, 5'd12, 5'd12, 5'd0, 5'd12, 5'd4, 5'd8},
    {5'd2, 5'd4, 5'd8, 5'd16, 5'd8, 5'd4, 5'd2},
    {5'd0, 5'd0, 5'd31, 5'd0, 5'd31, 5'd0, 5'd0},
    {5'd8, 5'd4, 5'd2, 5'd1, 5'd2, 5'd4, 5'd8},
    {5'd14, 5'd17, 5'd1, 5'd2, 5'd4, 5'd0, 5'd4},
    {5'd14, 5'd17, 5'd1, 5'd13, 5'd21, 5'd21, 5'd14},
    {5'd14, 5'd17, 5'd17, 5'd31, 5'd17, 5'd17, 5'd17},
    {5'd30, 5'd17, 5'd17, 5'd30, 5'd17, 5'd17, 5'd30},
    {5'd14, 5'd17, 5'd16, 5'd16, 5'd16, 5'd17, 5'd14},
    {5'd28, 5'd18, 5'd17, 5'd17, 5'd17, 5'd18, 5'd28},
    {5'd31, 5'd16, 5'd16, 5'd30, 5'd16, 5'd16, 5'd31},
    {5'd31, 5'd16, 5'd16, 5'd30, 5'd16, 5'd16, 5'd16},
    {5'd14, 5'd17, 5'd16, 5'd23, 5'd17, 5'd17, 5'd15},
    {5'd17, 5'd17, 5'd17, 5'd31, 5'd17, 5'd17, 5'd17},
    {5'd14, 5'd4, 5'd4, 5'd4, 5'd4, 5'd4, 5'd14},
    {5'd7, 5'd2, 5'd2, 5'd2, 5'd2, 5'd18, 5'd12},
    {5'd17, 5'd18, 5'd20, 5'd24, 5'd20, 5'd18, 5'd17},
    {5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd31},
    {5'd17, 5'd27, 5'd21, 5'd21, 5'd17, 5'd17, 5'd17},
    {5'd17, 5'd25, 5'd21, 5'd19, 5'd17, 5'd17, 5'd17},
    {5'd14, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd14},
    {5'd30, 5'd17, 5'd17, 5'd30, 5'd16, 5'd16, 5'd16},
    {5'd14, 5'd17, 5'd17, 5'd17, 5'd21, 5'd18, 5'd13},
    {5'd30, 5'd17, 5'd17, 5'd30, 5'd20, 5'd18, 5'd17},
    {5'd15, 5'd16, 5'd16, 5'd14, 5'd1, 5'd1, 5'd30},
    {5'd31, 5'd4, 5'd4, 5'd4, 5'd4, 5'd4, 5'd4},
    {5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd14},
    {5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd10, 5'd4},
    {5'd17, 5'd17, 5'd17, 5'd21, 5'd21, 5'd21, 5'd10},
    {5'd17, 5'd17, 5'd10, 5'd4, 5'd10, 5'd17, 5'd17},
    {5'd17, 5'd17, 5'd10, 5'd4, 5'd4, 5'd4, 5'd4},
    {5'd31, 5'd1, 5'd2, 5'd4, 5'd8, 5'd16, 5'd31},
    {5'd14, 5'd8, 5'd8, 5'd8, 5'd8, 5'd8, 5'd14},
    {5'd16, 5'd8, 5'd8, 5'd4, 5'd2, 5'd2, 5'd1},
    {5'd14, 5'd2, 5'd2, 5'd2, 5'd2, 5'd2, 5'd14},
    {5'd4, 5'd10, 5'd17, 5'd0, 5'd0, 5'd0, 5'd0},
    {5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd31}
  };

  function automatic logic [4:0] glyph_row(input logic [5:0] glyph, input logic [2:0] r);
    logic [34:0] g;
    g = GLYPH_ROM[glyph];
    case (r)
      3'd0:    glyph_row = g[34:30];
      3'd1:    glyph_row = g[29:25];
      3'd2:    glyph_row = g[24:20];
      3'd3:    glyph_row = g[19:15];
      3'd4:    glyph_row = g[14:10];
      3'd5:    glyph_row = g[9:5];
      3'd6:    glyph_row = g[4:0];
      default: glyph_row = 5'd0;
    endcase
  endfunction

endpackage

>>> hw/rtl/tcgw_cache.sv
// ----------------------------------------------------------------------------
// tcgw_cache
// Per-column glyph cache for cell row 0: registered-read store with valid
// flags and write-to-read forwarding for back-to-back items.
// ----------------------------------------------------------------------------
module tcgw_cache #(
  parameter int COLUMNS = 38
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                rd_en,
  input  logic [6:0]          rd_col,
  input  tcgw_pkg::cache_cmd_t cmd,
  output logic [6:0]          entry
);
  import tcgw_pkg::*;

  localparam int IDX_W = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;

  logic [6:0]         mem [COLUMNS];
  logic [COLUMNS-1:0] valid;
  logic [6:0]         rd_data;
  logic [6:0]         rd_col_q;
  logic               fwd_hit;
  logic [6:0]         fwd_val;
  logic               rd_inr;
  logic               q_inr;
  logic [IDX_W-1:0]   rd_idx;
  logic [IDX_W-1:0]   q_idx;
  logic [IDX_W-1:0]   wr_idx;

  assign rd_inr = {1'b0, rd_col} < 8'(COLUMNS);
  assign q_inr  = {1'b0, rd_col_q} < 8'(COLUMNS);
  assign rd_idx = rd_col[IDX_W-1:0];
  assign q_idx  = rd_col_q[IDX_W-1:0];
  assign wr_idx = cmd.wr_col[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_idx] <= cmd.wr_val;
    end
    if (rd_en) begin
      if (rd_inr) begin
        rd_data <= mem[rd_idx];
      end
      rd_col_q <= rd_col;
      // same-cycle write wins over the stale read
      fwd_hit  <= cmd.wr_en && (cmd.wr_col == rd_col);
      fwd_val  <= cmd.wr_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (cmd.clear) begin
      valid <= '0;
    end else if (cmd.wr_en) begin
      valid[wr_idx] <= 1'b1;
    end
  end

  assign entry = (q_inr && valid[q_idx]) ? (fwd_hit ? fwd_val : rd_data) : 7'd0;

endmodule

>>> hw/rtl/tcgw_emit.sv
// ----------------------------------------------------------------------------
// tcgw_emit
// Result sequencer: holds one job and hands out its scanline writes, one
// item per cycle while out_stall is low, or the single status item of a control command.
// ----------------------------------------------------------------------------
module tcgw_emit (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  tcgw_pkg::job_t      job_in,
  output logic                free,
  output logic                out_valid,
  input  logic                out_stall,
  output tcgw_pkg::out_item_t out_data
);
  import tcgw_pkg::*;

  logic       job_valid;
  job_t       job;
  logic [3:0] line;
  logic       fire;
  logic       is_last;
  logic       empty;
  logic [4:0] grow;
  logic [2:0] grow_idx;

  assign fire    = job_valid && !out_stall;
  assign is_last = job.single || (line == LAST_LINE);
  assign free    = !job_valid || (fire && is_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
    end else if (load) begin
      job_valid <= 1'b1;
    end else if (fire && is_last) begin
      job_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      job  <= job_in;
      line <= 4'd0;
    end else if (fire) begin
      line <= line + 4'd1;
    end
  end

  assign grow_idx = 3'(line - GLYPH_FIRST);
  assign grow     = glyph_row(job.glyph, grow_idx);
  assign empty    = (job.box.right == 8'd0);

  always_comb begin
    out_valid            = job_valid;
    out_data.write_valid = !job.single;
    out_data.byte_offset = job.single ? 17'd0 : {job.row, line, job.column};
    out_data.pixel_bits  = 8'd0;
    if (!job.single && (line inside {[GLYPH_FIRST:GLYPH_LAST]})) begin
      out_data.pixel_bits = {1'b0, grow, 2'b00};
    end
    out_data.last        = is_last;
    out_data.box_empty   = empty;
    out_data.box_left    = empty ? 8'd0  : job.box.left;
    out_data.box_top     = empty ? 11'd0 : job.box.top;
    out_data.box_right   = empty ? 8'd0  : job.box.right;
    out_data.box_bottom  = empty ? 11'd0 : job.box.bottom;
  end

endmodule

>>> hw/rtl/text_cell_glyph_writer.sv
// ----------------------------------------------------------------------------
// text_cell_glyph_writer
// An accepted item passes the input register, then the result sequencer,
// before its first result is offered. A drawn character gives one scanline
// byte a cycle through the single write port while the output does not
// stall; control items give a single status item, an unchanged cached glyph
// none. The next item enters while results drain.
// Reset clears the cache valid flags and the dirty box at once.
// ----------------------------------------------------------------------------
module text_cell_glyph_writer #(
  parameter int CACHE_COLUMNS = 38
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  tcgw_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output tcgw_pkg::out_item_t out_data
);
  import tcgw_pkg::*;

  logic       s1_valid;
  in_item_t   s1_item;
  logic       accept;
  logic       s1_go;
  logic       job_free;
  logic [6:0] cached;
  logic [5:0] glyph;
  logic [6:0] tag;
  logic       cacheable;
  logic       skip;
  logic       draw;
  logic       job_load;
  cache_cmd_t cmd;
  box_t       box;
  box_t       box_next;
  box_t       cell_box;
  job_t       job_new;

  assign in_stall = s1_valid && !s1_go;
  assign accept   = in_valid && !in_stall;
  assign s1_go    = s1_valid && job_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item <= in_data;
    end
  end

  // codes outside 0x20..0x5F draw the blank glyph
  assign glyph     = (s1_item.char_code inside {[GLYPH_LOW:GLYPH_HIGH]})
                     ? 6'(s1_item.char_code - GLYPH_LOW) : 6'd0;
  assign tag       = {1'b0, glyph} + 7'd1;
  assign cacheable = (s1_item.kind == KIND_PUT) && (s1_item.row == 6'd0)
                     && ({1'b0, s1_item.column} < 8'(CACHE_COLUMNS));
  assign skip      = cacheable && (cached == tag);
  assign draw      = s1_go && (s1_item.kind == KIND_PUT) && !skip;
  assign job_load  = s1_go && !skip;

  always_comb begin
    cmd.clear  = s1_go && (s1_item.kind == KIND_CLEAR);
    cmd.wr_en  = draw && cacheable;
    cmd.wr_col = s1_item.column;
    cmd.wr_val = tag;
  end

  tcgw_cache #(
    .COLUMNS (CACHE_COLUMNS)
  ) u_cache (
    .clk    (clk),
    .rst    (rst),
    .rd_en  (accept),
    .rd_col (in_data.column),
    .cmd    (cmd),
    .entry  (cached)
  );

  always_comb begin
    cell_box.left   = {1'b0, s1_item.column};
    cell_box.right  = {1'b0, s1_item.column} + 8'd1;
    cell_box.top    = {1'b0, s1_item.row, 4'd0};
    cell_box.bottom = {1'b0, s1_item.row, 4'd0} + 11'(CELL_LINES);
    box_next        = box;
    if (draw) begin
      if (box.right == 8'd0) begin
        box_next = cell_box;
      end else begin
        if (cell_box.left < box.left)     box_next.left   = cell_box.left;
        if (cell_box.top < box.top)       box_next.top    = cell_box.top;
        if (cell_box.right > box.right)   box_next.right  = cell_box.right;
        if (cell_box.bottom > box.bottom) box_next.bottom = cell_box.bottom;
      end
    end else if (s1_go && (s1_item.kind == KIND_EMPTY)) begin
      box_next.right = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      box <= '0;
    end else begin
      box <= box_next;
    end
  end

  always_comb begin
    job_new.single = (s1_item.kind != KIND_PUT);
    job_new.column = s1_item.column;
    job_new.row    = s1_item.row;
    job_new.glyph  = glyph;
    job_new.box    = box_next;
  end

  tcgw_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .load      (job_load),
    .job_in    (job_new),
    .free      (job_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  a_box_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.box_empty |->
      (out_data.box_left < out_data.box_right) && (out_data.box_top < out_data.box_bottom))
    else $error("dirty box corners out of order");

  a_status_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.write_valid |-> out_data.last)
    else $error("status item not marked last");

  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_go |=> s1_valid && $stable(s1_item))
    else $error("held item lost while the sequencer was busy");

  a_skip_no_write: assert property (@(posedge clk) disable iff (rst)
    s1_go && skip |-> !cmd.wr_en && !job_load && (box_next == box))
    else $error("unchanged glyph touched state");

endmodule

>>> tb/glyph_write_checker.sv
// ----------------------------------------------------------------------------
// glyph_write_checker
// Watches both channels of the text cell glyph writer, keeps its own copy of
// the glyph cache and dirty box, works out the scanline writes each accepted
// item should cause and compares every accepted result with the oldest one.
// ----------------------------------------------------------------------------
module glyph_write_checker #(
  parameter int CACHE_COLS = 38
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_stall,
  input  tcgw_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  logic                out_stall,
  input  tcgw_pkg::out_item_t out_data,
  output int                  mismatches,
  output int                  pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import tcgw_pkg::*;

  logic [6:0]  glyph_seen [CACHE_COLS];  // glyph index + 1, 0 = never drawn
  logic [7:0]  pred_left;
  logic [10:0] pred_top;
  logic [7:0]  pred_right;                 // 0 = box empty
  logic [10:0] pred_bottom;
  out_item_t   owed_results [$];

  // 5x7 font, top row in the high bits
  function automatic logic [34:0] font_5x7(input logic [5:0] idx);
    case (idx)
      6'd0:  font_5x7 = {5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0};
      6'd1:  font_5x7 = {5'd4, 5'd4, 5'd4, 5'd4, 5'd4, 5'd0, 5'd4};
      6'd2:  font_5x7 = {5'd10, 5'd10, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0};
      6'd3:  font_5x7 = {5'd10, 5'd31, 5'd10, 5'd10, 5'd31, 5'd10, 5'd0};
      6'd4:  font_5x7 = {5'd4, 5'd15, 5'd20, 5'd14, 5'd5, 5'd30, 5'd4};
      6'd5:  font_5x7 = {5'd25, 5'd26, 5'd2, 5'd4, 5'd8, 5'd11, 5'd19};
      6'd6:  font_5x7 = {5'd12, 5'd18, 5'd20, 5'd8, 5'd21, 5'd18, 5'd13};
      6'd7:  font_5x7 = {5'd4, 5'd4, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0};
      6'd8:  font_5x7 = {5'd2, 5'd4, 5'd8, 5'd8, 5'd8, 5'd4, 5'd2};
      6'd9:  font_5x7 = {5'd8, 5'd4, 5'd2, 5'd2, 5'd2, 5'd4, 5'd8};
      6'd10: font_5x7 = {5'd0, 5'd10, 5'd4, 5'd31, 5'd4, 5'd10, 5'd0};
      6'd11: font_5x7 = {5'd0, 5'd4, 5'd4, 5'd31, 5'd4, 5'd4, 5'd0};
      6'd12: font_5x7 = {5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd4, 5'd8};
      6'd13: font_5x7 = {5'd0, 5'd0, 5'd0, 5'd31, 5'd0, 5'd0, 5'd0};
      6'd14: font_5x7 = {5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd12, 5'd12};
      6'd15: font_5x7 = {5'd1, 5'd2, 5'd2, 5'd4, 5'd8, 5'd8, 5'd16};
      6'd16: font_5x7 = {5'd14, 5'd17, 5'd19, 5'd21, 5'd25, 5'd17, 5'd14};
      6'd17: font_5x7 = {5'd4, 5'd12, 5'd4, 5'd4, 5'd4, 5'd4, 5'd14};
      6'd18: font_5x7 = {5'd14, 5'd17, 5'd1, 5'd2, 5'd4, 5'd8, 5'd31};
      6'd19: font_5x7 = {5'd31, 5'd2, 5'd4, 5'd2, 5'd1, 5'd17, 5'd14};
      6'd20: font_5x7 = {5'd2, 5'd6, 5'd10, 5'd18, 5'd31, 5'd2, 5'd2};
      6'd21: font_5x7 = {5'd31, 5'd16, 5'd30, 5'd1, 5'd1, 5'd17, 5'd14};
      6'd22: font_5x7 = {5'd6, 5'd8, 5'd16, 5'd30, 5'd17, 5'd17, 5'd14};
      6'd23: font_5x7 = {5'd31, 5'd1, 5'd2, 5'd4, 5'd8, 5'd8, 5'd8};
      6'd24: font_5x7 = {5'd14, 5'd17, 5'd17, 5'd14, 5'd17, 5'd17, 5'd14};
      6'd25: font_5x7 = {5'd14, 5'd17, 5'd17, 5'd15, 5'd1, 5'd2, 5'd12};
      6'd26: font_5x7 = {5'd0, 5'd12, 5'd12, 5'd0, 5'd12, 5'd12, 5'd0};
      6'd27: font_5x7 = {5'd0, 5'd12, 5'd12, 5'd0, 5'd12, 5'd4, 5'd8};
      6'd28: font_5x7 = {5'd2, 5'd4, 5'd8, 5'd16, 5'd8, 5'd4, 5'd2};
      6'd29: font_5x7 = {5'd0, 5'd0, 5'd31, 5'd0, 5'd31, 5'd0, 5'd0};
      6'd30: font_5x7 = {5'd8, 5'd4, 5'd2, 5'd1, 5'd2, 5'd4, 5'd8};
      6'd31: font_5x7 = {5'd14, 5'd17, 5'd1, 5'd2, 5'd4, 5'd0, 5'd4};
      6'd32: font_5x7 = {5'd14, 5'd17, 5'd1, 5'd13, 5'd21, 5'd21, 5'd14};
      6'd33: font_5x7 = {5'd14, 5'd17, 5'd17, 5'd31, 5'd17, 5'd17, 5'd17};
      6'd34: font_5x7 = {5'd30, 5'd17, 5'd17, 5'd30, 5'd17, 5'd17, 5'd30};
      6'd35: font_5x7 = {5'd14, 5'd17, 5'd16, 5'd16, 5'd16, 5'd17, 5'd14};
      6'd36: font_5x7 = {5'd28, 5'd18, 5'd17, 5'd17, 5'd17, 5'd18, 5'd28};
      6'd37: font_5x7 = {5'd31, 5'd16, 5'd16, 5'd30, 5'd16, 5'd16, 5'd31};
      6'd38: font_5x7 = {5'd31, 5'd16, 5'd16, 5'd30, 5'd16, 5'd16, 5'd16};
      6'd39: font_5x7 = {5'd14, 5'd17, 5'd16, 5'd23, 5'd17, 5'd17, 5'd15};
      6'd40: font_5x7 = {5'd17, 5'd17, 5'd17, 5'd31, 5'd17, 5'd17, 5'd17};
      6'd41: font_5x7 = {5'd14, 5'd4, 5'd4, 5'd4, 5'd4, 5'd4, 5'd14};
      6'd42: font_5x7 = {5'd7, 5'd2, 5'd2, 5'd2, 5'd2, 5'd18, 5'd12};
      6'd43: font_5x7 = {5'd17, 5'd18, 5'd20, 5'd24, 5'd20, 5'd18, 5'd17};
      6'd44: font_5x7 = {5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd31};
      6'd45: font_5x7 = {5'd17, 5'd27, 5'd21, 5'd21, 5'd17, 5'd17, 5'd17};
      6'd46: font_5x7 = {5'd17, 5'd25, 5'd21, 5'd19, 5'd17, 5'd17, 5'd17};
      6'd47: font_5x7 = {5'd14, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd14};
      6'd48: font_5x7 = {5'd30, 5'd17, 5'd17, 5'd30, 5'd16, 5'd16, 5'd16};
      6'd49: font_5x7 = {5'd14, 5'd17, 5'd17, 5'd17, 5'd21, 5'd18, 5'd13};
      6'd50: font_5x7 = {5'd30, 5'd17, 5'd17, 5'd30, 5'd20, 5'd18, 5'd17};
      6'd51: font_5x7 = {5'd15, 5'd16, 5'd16, 5'd14, 5'd1, 5'd1, 5'd30};
      6'd52: font_5x7 = {5'd31, 5'd4, 5'd4, 5'd4, 5'd4, 5'd4, 5'd4};
      6'd53: font_5x7 = {5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd14};
      6'd54: font_5x7 = {5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd10, 5'd4};
      6'd55: font_5x7 = {5'd17, 5'd17, 5'd17, 5'd21, 5'd21, 5'd21, 5'd10};
      6'd56: font_5x7 = {5'd17, 5'd17, 5'd10, 5'd4, 5'd10, 5'd17, 5'd17};
      6'd57: font_5x7 = {5'd17, 5'd17, 5'd10, 5'd4, 5'd4, 5'd4, 5'd4};
      6'd58: font_5x7 = {5'd31, 5'd1, 5'd2, 5'd4, 5'd8, 5'd16, 5'd31};
      6'd59: font_5x7 = {5'd14, 5'd8, 5'd8, 5'd8, 5'd8, 5'd8, 5'd14};
      6'd60: font_5x7 = {5'd16, 5'd8, 5'd8, 5'd4, 5'd2, 5'd2, 5'd1};
      6'd61: font_5x7 = {5'd14, 5'd2, 5'd2, 5'd2, 5'd2, 5'd2, 5'd14};
      6'd62: font_5x7 = {5'd4, 5'd10, 5'd17, 5'd0, 5'd0, 5'd0, 5'd0};
      default: font_5x7 = {5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd31};
    endcase
  endfunction

  // box fields as they read after the current update
  function automatic out_item_t with_box(input out_item_t r);
    out_item_t o;
    o = r;
    o.box_empty  = (pred_right == 8'd0);
    o.box_left   = o.box_empty ? 8'd0  : pred_left;
    o.box_top    = o.box_empty ? 11'd0 : pred_top;
    o.box_right  = o.box_empty ? 8'd0  : pred_right;
    o.box_bottom = o.box_empty ? 11'd0 : pred_bottom;
    return o;
  endfunction

  task automatic render_item(input in_item_t it);
    logic [5:0]  idx;
    logic [6:0]  tag;
    logic [10:0] top_line;
    logic [34:0] glyph;
    logic [4:0]  bits5;
    out_item_t   r;
    int          y;
    r = '0;
    r.last = 1'b1;
    case (it.kind)
      KIND_CLEAR: begin
        for (int i = 0; i < CACHE_COLS; i++) glyph_seen[i] = 7'd0;
        owed_results.push_back(with_box(r));
      end
      KIND_EMPTY: begin
        pred_right = 8'd0;  // other corners are kept
        owed_results.push_back(with_box(r));
      end
      KIND_PUT: begin
        idx = (it.char_code >= 8'h20 && it.char_code < 8'h60) ? 6'(it.char_code - 8'h20)
                                                               : 6'd0;
        tag = {1'b0, idx} + 7'd1;
        if (it.row == 6'd0 && int'(it.column) < CACHE_COLS) begin
          if (glyph_seen[it.column] == tag) return;  // same glyph already there
          glyph_seen[it.column] = tag;
        end
        top_line = {1'b0, it.row, 4'd0};
        if (pred_right == 8'd0) begin
          pred_left   = {1'b0, it.column};
          pred_top    = top_line;
          pred_right  = {1'b0, it.column} + 8'd1;
          pred_bottom = top_line + 11'd16;
        end else begin
          if ({1'b0, it.column} < pred_left) pred_left = {1'b0, it.column};
          if (top_line < pred_top) pred_top = top_line;
          if ({1'b0, it.column} + 8'd1 > pred_right) pred_right = {1'b0, it.column} + 8'd1;
          if (top_line + 11'd16 > pred_bottom) pred_bottom = top_line + 11'd16;
        end
        glyph = font_5x7(idx);
        for (y = 0; y < 16; y++) begin
          bits5 = (y >= 4 && y <= 10) ? glyph[34 - 5 * (y - 4) -: 5] : 5'd0;
          r.write_valid = 1'b1;
          r.byte_offset = 17'((int'(top_line) + y) * 128 + int'(it.column));
          r.pixel_bits  = {1'b0, bits5, 2'b00};
          r.last        = (y == 15);
          owed_results.push_back(with_box(r));
        end
      end
      default: owed_results.push_back(with_box(r));  // unused kind: no change
    endcase
  endtask

  task automatic flag(input string why, input out_item_t got, input out_item_t want);
    if (mismatches < 10) begin
      $display("%0t: %s", $realtime, why);
      $display("  want wv=%0d off=%05h bits=%02h last=%0d empty=%0d box=%0d,%0d,%0d,%0d",
               want.write_valid, want.byte_offset, want.pixel_bits, want.last,
               want.box_empty, want.box_left, want.box_top, want.box_right, want.box_bottom);
      $display("  got  wv=%0d off=%05h bits=%02h last=%0d empty=%0d box=%0d,%0d,%0d,%0d",
               got.write_valid, got.byte_offset, got.pixel_bits, got.last,
               got.box_empty, got.box_left, got.box_top, got.box_right, got.box_bottom);
    end
    mismatches++;
  endtask

  always @(posedge clk) begin : watch
    out_item_t want;
    if (rst) begin
      for (int i = 0; i < CACHE_COLS; i++) glyph_seen[i] = 7'd0;
      pred_left   = 8'd0;
      pred_top    = 11'd0;
      pred_right  = 8'd0;
      pred_bottom = 11'd0;
      owed_results.delete();
    end else begin
      // inputs first: anything leaving now belongs to older items
      if (in_valid === 1'b1 && in_stall === 1'b0) render_item(in_data);
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        if (owed_results.size() == 0) begin
          flag("result with nothing owed", out_data, '0);
        end else begin
          want = owed_results.pop_front();
          if (out_data !== want) flag("result mismatch", out_data, want);
        end
      end
    end
    pending <= owed_results.size();
  end

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives put-character, clear-cache, empty-box and unused-kind items into the
// text cell glyph writer with random gaps and output stalls; a checker beside
// the block predicts and compares every scanline write and box update.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import tcgw_pkg::*;

  localparam int CACHE_COLS = 38;
  localparam int IDLE_PCT   = 24;
  localparam int RAND_ITEMS = 407;

  logic      clk;
  logic      rst       = 1'b1;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;
  int        mismatches;
  int        pending;
  logic      calm      = 1'b0;  // no idling on either side while set

  text_cell_glyph_writer #(.CACHE_COLUMNS(CACHE_COLS)) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  glyph_write_checker #(.CACHE_COLS(CACHE_COLS)) u_check (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .mismatches (mismatches),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= calm ? 1'b0 : ($urandom_range(99) < IDLE_PCT);
  end

  // valid stays high after acceptance; the next call lowers it or moves on
  task automatic send(input in_item_t it);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      in_data  <= in_item_t'(23'($urandom));
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall !== 1'b0);
  endtask

  task automatic draw_char(input logic [6:0] col, input logic [5:0] row,
                           input logic [7:0] code);
    in_item_t it;
    it.kind      = KIND_PUT;
    it.column    = col;
    it.row       = row;
    it.char_code = code;
    send(it);
  endtask

  task automatic control(input kind_t k);
    in_item_t it;
    it           = in_item_t'(23'($urandom));
    it.kind      = k;
    send(it);
  endtask

  initial begin : stimulus
    in_item_t it;
    int       counted;
    int       pick;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed
    draw_char(7'd0, 6'd0, 8'h41);     // cached cell, box grows from empty
    draw_char(7'd0, 6'd0, 8'h41);     // unchanged glyph: nothing
    draw_char(7'd0, 6'd0, 8'h20);     // blank replaces it
    draw_char(7'd0, 6'd0, 8'h00);     // out of range code is blank too: nothing
    draw_char(7'd37, 6'd0, 8'h5F);    // last cached column
    draw_char(7'd37, 6'd0, 8'h5F);
    draw_char(7'd38, 6'd0, 8'h5E);    // first uncached column, drawn both times
    draw_char(7'd38, 6'd0, 8'h5E);
    draw_char(7'd127, 6'd63, 8'h5F);  // far corner, largest offset and box
    draw_char(7'd5, 6'd1, 8'h41);     // row 1 never cached
    draw_char(7'd5, 6'd1, 8'h41);
    control(KIND_CLEAR);
    draw_char(7'd0, 6'd0, 8'h20);     // cache forgotten: drawn again
    control(KIND_EMPTY);
    control(KIND_EMPTY);              // already empty
    control(KIND_NONE);
    draw_char(7'd64, 6'd32, 8'h1F);   // box restarts from this cell
    draw_char(7'd10, 6'd0, 8'h60);
    draw_char(7'd20, 6'd40, 8'h80);
    draw_char(7'd1, 6'd2, 8'hFF);
    draw_char(7'd2, 6'd0, 8'h7F);
    control(KIND_CLEAR);
    draw_char(7'd0, 6'd0, 8'h30);

    counted = 0;
    while (counted < RAND_ITEMS) begin
      calm = (counted >= 200 && counted < 280);
      pick = $urandom_range(99);
      it   = in_item_t'(23'($urandom));
      if (pick < 45) begin
        // row 0 with few glyphs, so repeats hit the cache often
        it.kind   = KIND_PUT;
        it.row    = 6'd0;
        it.column = $urandom_range(1) ? 7'($urandom_range(9)) : 7'($urandom_range(30, 41));
        if ($urandom_range(3) != 0) it.char_code = 8'h41 + 8'($urandom_range(3));
      end else if (pick < 78) begin
        it.kind = KIND_PUT;
        if ($urandom_range(3) != 0) it.char_code = 8'($urandom_range(8'h20, 8'h5F));
      end else if (pick < 87) begin
        it.kind = KIND_CLEAR;
      end else if (pick < 96) begin
        it.kind = KIND_EMPTY;
      end else begin
        it.kind = KIND_NONE;
      end
      send(it);
      counted++;
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    @(posedge clk);
    wait (pending == 0);
    repeat (24) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("** text_cell_glyph_writer: PASSED **");
    end else begin
      $display("** text_cell_glyph_writer: FAILED **");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("** text_cell_glyph_writer: FAILED **");
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/tcgw_pkg.sv
hw/rtl/tcgw_cache.sv
hw/rtl/tcgw_emit.sv
hw/rtl/text_cell_glyph_writer.sv
tb/glyph_write_checker.sv
tb/testbench.sv
